// ===== hdl/utc_dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTC date-time checker package
// Error codes, result structs and the calendar and BCD helper functions.
// ----------------------------------------------------------------------------
package utc_dtc_pkg;

  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int ERR_W   = 3;
  localparam int MLEN_W  = 5;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MONTH   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_DAY     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HOUR    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_MINUTE  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_SECOND  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_NO_LEAP = 3'd6;

  typedef struct packed {
    logic        leap;
    logic [15:0] ybcd;
  } year_info_t;

  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic              lsd;
    logic [MLEN_W-1:0] mlen;
  } check_info_t;

  // two BCD digits of a value below 200, taken modulo 100
  function automatic logic [7:0] bcd2(input logic [7:0] v);
    logic [7:0] w;
    logic [3:0] t;
    logic [7:0] tx10;
    logic [7:0] o;
    w = (v >= 8'd100) ? (v - 8'd100) : v;
    if (w >= 8'd90) t = 4'd9;
    else if (w >= 8'd80) t = 4'd8;
    else if (w >= 8'd70) t = 4'd7;
    else if (w >= 8'd60) t = 4'd6;
    else if (w >= 8'd50) t = 4'd5;
    else if (w >= 8'd40) t = 4'd4;
    else if (w >= 8'd30) t = 4'd3;
    else if (w >= 8'd20) t = 4'd2;
    else if (w >= 8'd10) t = 4'd1;
    else t = 4'd0;
    tx10 = {4'd0, t} * 8'd10;
    o = w - tx10;
    return {t, o[3:0]};
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(input logic leap,
                                                  input logic [FIELD_W-1:0] m);
    logic [MLEN_W-1:0] r;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     r = 5'd30;
      7'd2:                                        r = leap ? 5'd29 : 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // inserted leap seconds, 1972 to 2016
  function automatic logic leap_second_on(input logic [YEAR_W-1:0] y,
                                          input logic [FIELD_W-1:0] m,
                                          input logic [FIELD_W-1:0] d);
    logic jun;
    logic dec;
    logic r;
    jun = (m == 7'd6) && (d == 7'd30);
    dec = (m == 7'd12) && (d == 7'd31);
    priority if (!(jun || dec)) r = 1'b0;
    else if (y < 14'd1972 || y > 14'd2016) r = 1'b0;
    else if (y == 14'd1972) r = 1'b1;
    else if (y < 14'd1980) r = dec;
    else if (y == 14'd1980 || y == 14'd1984 || y == 14'd1986) r = 1'b0;
    else if (y < 14'd1986) r = jun;
    else if (y == 14'd1988 || y == 14'd1991) r = 1'b0;
    else if (y < 14'd1991) r = dec;
    else if (y < 14'd1995) r = jun;
    else if (y == 14'd1995) r = dec;
    else if (y == 14'd1996) r = 1'b0;
    else if (y == 14'd1997) r = jun;
    else if (y == 14'd1998) r = dec;
    else if (y == 14'd2005 || y == 14'd2008 || y == 14'd2016) r = dec;
    else if (y == 14'd2012 || y == 14'd2015) r = jun;
    else r = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/utc_dtc_year.sv =====
// ----------------------------------------------------------------------------
// UTC date-time checker: year unit
// Splits the year by 100 with a reciprocal multiply; gives leap flag and BCD.
// ----------------------------------------------------------------------------
module utc_dtc_year
  import utc_dtc_pkg::*;
(
  input  logic [YEAR_W-1:0] year,
  output year_info_t        info
);

  logic [26:0]       prod;
  logic [7:0]        q;
  logic [13:0]       qx100;
  logic [13:0]       r;

  assign prod  = {13'd0, year} * 27'd5243;
  assign q     = prod[26:19];
  assign qx100 = {6'd0, q} * 14'd100;
  assign r     = year - qx100;

  assign info.leap = (year[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  assign info.ybcd = {bcd2(q), bcd2({1'b0, r[6:0]})};

endmodule

// ===== hdl/utc_dtc_check.sv =====
// ----------------------------------------------------------------------------
// UTC date-time checker: field check
// Month length, leap-second lookup and first failing check.
// ----------------------------------------------------------------------------
module utc_dtc_check
  import utc_dtc_pkg::*;
(
  input  logic [YEAR_W-1:0]  year,
  input  logic               leap,
  input  logic [FIELD_W-1:0] month,
  input  logic [FIELD_W-1:0] day,
  input  logic [FIELD_W-1:0] hour,
  input  logic [FIELD_W-1:0] minute,
  input  logic [FIELD_W-1:0] second,
  output check_info_t        info
);

  logic [MLEN_W-1:0] mlen;
  logic              lsd;
  logic [ERR_W-1:0]  err;

  assign mlen = month_len(leap, month);
  assign lsd  = leap_second_on(year, month, day);

  always_comb begin
    priority if (mlen == 5'd0) err = ERR_MONTH;
    else if (day == 7'd0 || day > {2'd0, mlen}) err = ERR_DAY;
    else if (hour > 7'd23) err = ERR_HOUR;
    else if (minute > 7'd59) err = ERR_MINUTE;
    else if (second > 7'd60) err = ERR_SECOND;
    else if (second == 7'd60 && (hour != 7'd23 || minute != 7'd59)) err = ERR_SECOND;
    else if (second == 7'd60 && !lsd) err = ERR_NO_LEAP;
    else err = ERR_OK;
  end

  assign info.err  = err;
  assign info.lsd  = lsd;
  assign info.mlen = mlen;

endmodule

// ===== hdl/utc_date_time_checker_top.sv =====
// ----------------------------------------------------------------------------
// UTC date-time checker
// The start beat is registered in in_vld and then in the done strobe.
// Throughput: one beat per cycle; busy is always low, set by the single
// check pass between the input and result registers.
// Reset clears the input and result strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module utc_date_time_checker_top
  import utc_dtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  year,
  input  logic [FIELD_W-1:0] month,
  input  logic [FIELD_W-1:0] day,
  input  logic [FIELD_W-1:0] hour,
  input  logic [FIELD_W-1:0] minute,
  input  logic [FIELD_W-1:0] second,
  output logic               done,
  output logic               valid_res,
  output logic [ERR_W-1:0]   error_code,
  output logic               leap_year,
  output logic               leap_second_day,
  output logic [MLEN_W-1:0]  month_length,
  output logic [31:0]        date_bcd,
  output logic [23:0]        time_bcd
);

  logic               in_vld;
  logic [YEAR_W-1:0]  year_q;
  logic [FIELD_W-1:0] month_q;
  logic [FIELD_W-1:0] day_q;
  logic [FIELD_W-1:0] hour_q;
  logic [FIELD_W-1:0] minute_q;
  logic [FIELD_W-1:0] second_q;
  year_info_t         yinfo;
  check_info_t        cinfo;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      year_q   <= year;
      month_q  <= month;
      day_q    <= day;
      hour_q   <= hour;
      minute_q <= minute;
      second_q <= second;
    end
  end

  utc_dtc_year u_year (
    .year (year_q),
    .info (yinfo)
  );

  utc_dtc_check u_check (
    .year   (year_q),
    .leap   (yinfo.leap),
    .month  (month_q),
    .day    (day_q),
    .hour   (hour_q),
    .minute (minute_q),
    .second (second_q),
    .info   (cinfo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      valid_res       <= (cinfo.err == ERR_OK);
      error_code      <= cinfo.err;
      leap_year       <= yinfo.leap;
      leap_second_day <= cinfo.lsd;
      month_length    <= cinfo.mlen;
      date_bcd        <= {yinfo.ybcd, bcd2({1'b0, month_q}), bcd2({1'b0, day_q})};
      time_bcd        <= {bcd2({1'b0, hour_q}), bcd2({1'b0, minute_q}),
                          bcd2({1'b0, second_q})};
    end
  end

endmodule
